FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define ASSERT_ON(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Expression must never be true.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

FILE: src/pdf_pkg.sv
`timescale 1ns / 1ps

package pdf_pkg;

	localparam int HASH_W  = 64;
	localparam int STAMP_W = 48;
	localparam int RET_W   = 32;

	// Retention register: reset value and index (paddr[2])
	localparam logic [RET_W-1:0] RETENTION_RST = 32'd1000;
	localparam logic             REG_RETENTION = 1'b0;

	// Input request: one payload byte
	typedef struct packed {
		logic [7:0]         payload_byte;
		logic               last_byte;
		logic [STAMP_W-1:0] now_ms;
	} in_req_t;

	// Output request: one verdict per packet
	typedef struct packed {
		logic              is_duplicate;
		logic [HASH_W-1:0] packet_hash;
	} out_req_t;

	// One history entry
	typedef struct packed {
		logic               valid;
		logic [HASH_W-1:0]  hash;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// Broadcast control from the walk sequencer to every cell
	typedef struct packed {
		logic start;
		logic adv;
		logic drop;
		logic push;
		logic done;
	} cell_ctl_t;

	// Per-cell status, only the token holder reports
	typedef struct packed {
		logic tv;
		logic te;
		logic tm;
	} cell_st_t;

	// Finished packet hash from the hash front end
	typedef struct packed {
		logic               valid;
		logic [HASH_W-1:0]  hash;
		logic [STAMP_W-1:0] stamp;
	} hash_fin_t;

endpackage

FILE: src/pdf_hash.sv
`timescale 1ns / 1ps

module pdf_hash #(
	parameter int MAX_PAYLOAD = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  pdf_pkg::in_req_t  in_req,
	output pdf_pkg::hash_fin_t fin
);
	import pdf_pkg::*;

	localparam int KW = $clog2(MAX_PAYLOAD + 1);
	localparam int SW = (KW + 4 > 8) ? KW + 4 : 9;
	localparam int PW = SW + KW + 1;

	logic [KW-1:0]          pos_q;
	logic                   in_range;
	logic [KW-1:0]          k;
	logic signed [SW-1:0]   s_ext;
	logic [SW-1:0]          k7;
	logic signed [SW-1:0]   sum_w;
	logic signed [PW-1:0]   prod_w;

	logic                   vld_s1;
	logic                   last_s1;
	logic [STAMP_W-1:0]     now_s1;
	logic signed [PW-1:0]   prod_s1;

	logic [HASH_W-1:0]      acc_q;
	logic [HASH_W-1:0]      acc_next;

	// Term (s + 7k) * k, zero past the payload limit
	assign in_range = pos_q < KW'(MAX_PAYLOAD);
	assign k        = pos_q + 1'b1;
	assign s_ext    = $signed({{(SW-8){in_req.payload_byte[7]}}, in_req.payload_byte});
	assign k7       = (SW'(k) << 3) - SW'(k);
	assign sum_w    = s_ext + $signed(k7);
	assign prod_w   = sum_w * $signed({1'b0, k});

	// Byte position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (in_req.last_byte) begin
				pos_q <= '0;
			end else if (in_range) begin
				pos_q <= k;
			end
		end
	end

	// Stage 1: product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= in_req.last_byte;
			now_s1  <= in_req.now_ms;
			prod_s1 <= in_range ? prod_w : '0;
		end
	end

	// Stage 2: wrapping accumulate, cleared at packet end
	assign acc_next = acc_q + {{(HASH_W-PW){prod_s1[PW-1]}}, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= last_s1 ? '0 : acc_next;
		end
	end

	assign fin.valid = vld_s1 & last_s1;
	assign fin.hash  = acc_next;
	assign fin.stamp = now_s1;

endmodule

FILE: src/pdf_cell.sv
`timescale 1ns / 1ps

module pdf_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdf_pkg::cell_ctl_t   ctl,
	input  logic [47:0]          thr,
	input  logic                 never,
	input  logic [63:0]          key,
	input  pdf_pkg::entry_t      prev_ent,
	input  pdf_pkg::entry_t      next_ent,
	input  logic                 tok_in,
	output pdf_pkg::entry_t      ent,
	output logic                 tok,
	output pdf_pkg::cell_st_t    st
);
	import pdf_pkg::*;

	logic               valid_q;
	logic [HASH_W-1:0]  hash_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               tok_q;
	logic               ge_q;
	logic               expired;
	logic               hit;
	logic               load_prev;
	logic               load_next;

	// Local checks against the broadcast key and threshold
	assign expired = valid_q & ~never & (stamp_q < thr);
	assign hit     = hash_q == key;

	assign st.tv = tok_q & valid_q;
	assign st.te = tok_q & expired;
	assign st.tm = tok_q & valid_q & ~expired & hit;

	// Shift right on insert, shift left from the token onward on removal
	assign load_prev = ctl.push;
	assign load_next = ctl.drop & ge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_prev) begin
			valid_q <= prev_ent.valid;
		end else if (load_next) begin
			valid_q <= next_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_prev) begin
			hash_q  <= prev_ent.hash;
			stamp_q <= prev_ent.stamp;
		end else if (load_next) begin
			hash_q  <= next_ent.hash;
			stamp_q <= next_ent.stamp;
		end
	end

	// Walk token and "not yet passed" flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			ge_q  <= 1'b0;
		end else begin
			if (ctl.done) begin
				tok_q <= 1'b0;
			end else if (ctl.start | ctl.adv) begin
				tok_q <= tok_in;
			end
			if (ctl.start) begin
				ge_q <= 1'b1;
			end else if (ctl.adv & tok_q) begin
				ge_q <= 1'b0;
			end
		end
	end

	assign ent.valid = valid_q;
	assign ent.hash  = hash_q;
	assign ent.stamp = stamp_q;
	assign tok       = tok_q;

endmodule

FILE: src/packet_duplicate_filter.sv
`timescale 1ns / 1ps
// Channel  | Ports                          | Moves
// ---------+--------------------------------+------------------------------------
// input    | in_valid, in_stall, in_req     | one payload byte per request
// output   | out_valid, out_stall, out_req  | one verdict per packet
// config   | psel/penable/pwrite/paddr/...  | retention_ms at byte address 0
//
// A byte is taken every cycle within a packet; the packet hash is ready in the cycle
// after the last byte. That cycle starts the history walk, which then takes one step
// per entry passed or removed plus one closing step, the token stepping one cell
// down the cell row for each entry passed.
// in_stall stays high from the last byte until the verdict is registered.
// The walk holds its final step while a previous verdict is stalled on the output.
// Reset empties the history and sets retention_ms to 1000.
`include "assert_macros.svh"

module packet_duplicate_filter #(
	parameter int HISTORY_DEPTH = 16,
	parameter int MAX_PAYLOAD   = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pdf_pkg::in_req_t  in_req,
	output logic              out_valid,
	input  logic              out_stall,
	output pdf_pkg::out_req_t out_req,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import pdf_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic               state_q;
	logic [RET_W-1:0]   ret_q;
	logic [HASH_W-1:0]  key_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] thr_q;
	logic               never_q;
	logic [STAMP_W:0]   diff;

	logic               accept;
	hash_fin_t          fin;
	cell_ctl_t          ctl;
	entry_t             head_ent;
	entry_t             tail_ent;

	entry_t             ent_vec [HISTORY_DEPTH];
	cell_st_t           st_vec  [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] tok_vec;
	logic [HISTORY_DEPTH-1:0] tv_vec;
	logic [HISTORY_DEPTH-1:0] te_vec;
	logic [HISTORY_DEPTH-1:0] tm_vec;
	logic [HISTORY_DEPTH-1:0] vld_vec;

	logic               any_tv;
	logic               any_te;
	logic               any_tm;
	logic               walking;
	logic               slot_free;
	logic               end_nf;
	logic               end_dup;
	logic               finish;

	logic               out_valid_q;
	out_req_t           out_q;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RETENTION) ? ret_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q <= RETENTION_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RETENTION)) begin
			ret_q <= pwdata;
		end
	end

	// Hash front end
	assign in_stall = (state_q != ST_IDLE) | fin.valid;
	assign accept   = in_valid & ~in_stall;

	pdf_hash #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.in_req (in_req),
		.fin    (fin)
	);

	// Expiry threshold: entry expires when stamp < now - retention
	assign diff = {1'b0, fin.stamp} - {{(STAMP_W+1-RET_W){1'b0}}, ret_q};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			key_q   <= fin.hash;
			now_q   <= fin.stamp;
			thr_q   <= diff[STAMP_W-1:0];
			never_q <= diff[STAMP_W];
		end
	end

	// Cell row, newest entry in cell 0
	assign head_ent.valid = 1'b1;
	assign head_ent.hash  = key_q;
	assign head_ent.stamp = now_q;
	assign tail_ent       = '0;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		entry_t prev_ent;
		entry_t next_ent;
		logic   tok_in;

		if (i == 0) begin : g_first
			assign prev_ent = head_ent;
			assign tok_in   = ctl.start;
		end else begin : g_mid
			assign prev_ent = ent_vec[i-1];
			assign tok_in   = tok_vec[i-1];
		end
		if (i == HISTORY_DEPTH - 1) begin : g_last
			assign next_ent = tail_ent;
		end else begin : g_inner
			assign next_ent = ent_vec[i+1];
		end

		pdf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.thr      (thr_q),
			.never    (never_q),
			.key      (key_q),
			.prev_ent (prev_ent),
			.next_ent (next_ent),
			.tok_in   (tok_in),
			.ent      (ent_vec[i]),
			.tok      (tok_vec[i]),
			.st       (st_vec[i])
		);

		assign tv_vec[i]  = st_vec[i].tv;
		assign te_vec[i]  = st_vec[i].te;
		assign tm_vec[i]  = st_vec[i].tm;
		assign vld_vec[i] = ent_vec[i].valid;
	end

	// Status from the token holder
	assign any_tv = |tv_vec;
	assign any_te = |te_vec;
	assign any_tm = |tm_vec;

	// Walk step decision
	assign walking   = state_q == ST_WALK;
	assign slot_free = ~out_valid_q | ~out_stall;
	assign end_nf    = ~any_tv;
	assign end_dup   = any_tv & ~any_te & any_tm;
	assign finish    = walking & (end_nf | end_dup) & slot_free;

	assign ctl.start = (state_q == ST_IDLE) & fin.valid;
	assign ctl.drop  = walking & any_tv & any_te;
	assign ctl.adv   = walking & any_tv & ~any_te & ~any_tm;
	assign ctl.push  = finish & end_nf;
	assign ctl.done  = finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (ctl.start) state_q <= ST_WALK;
				ST_WALK: if (finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.is_duplicate <= end_dup;
			out_q.packet_hash  <= key_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_q;

	// At most one cell holds the walk token
	`ASSERT_ON(a_tok_onehot, $onehot0(tok_vec), "walk token held by more than one cell")
	// Valid entries form a prefix of the row
	`ASSERT_ON(a_vld_prefix, (vld_vec & (vld_vec + 1'b1)) == '0, "hole in history table")
	// A finished hash only appears while no walk runs
	`ASSERT_NEVER(a_fin_in_walk, fin.valid && walking, "packet end arrived during a walk")

endmodule
